/* rtl/smd5_pkg.sv */
package smd5_pkg;

  localparam int WORD_W    = 32;
  localparam int BUF_WORDS = 16;
  localparam int UPC_W     = 4;

  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [5:0]       rnd_t;
  typedef logic [5:0]       pos_t;

  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam pos_t        PAD_END_POS = 6'd56;
  localparam pos_t        LAST_POS    = 6'd63;
  localparam logic [63:0] BYTE_BITS   = 64'd8;

  localparam logic [WORD_W-1:0] IV_WORD [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [WORD_W-1:0] SEED_MUL [4] = '{32'd11, 32'd71, 32'd37, 32'd97};

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROUND_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NOP,
    OP_PUT_80,
    OP_PUT_ZERO,
    OP_PUT_LEN,
    OP_EMIT,
    OP_LOAD_IV,
    OP_CMP_START,
    OP_ROUND,
    OP_CMP_END
  } op_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NOT_FIN,
    CND_POS56,
    CND_EMIT_MORE,
    CND_ROUND_MORE,
    CND_RETURN
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  call_full;
    upc_t  ret;
  } ucode_t;

  localparam upc_t STEP_IDLE    = 4'd0;
  localparam upc_t STEP_PUT80   = 4'd1;
  localparam upc_t STEP_PADCHK  = 4'd2;
  localparam upc_t STEP_PUTZ    = 4'd3;
  localparam upc_t STEP_PUTL    = 4'd4;
  localparam upc_t STEP_EMIT    = 4'd5;
  localparam upc_t STEP_LOAD    = 4'd6;
  localparam upc_t STEP_CMP     = 4'd7;
  localparam upc_t STEP_ROUND   = 4'd8;
  localparam upc_t STEP_CMP_END = 4'd9;

  // A step that places a byte and sets call_full enters the compression
  // routine when the block fills, and that routine returns to ret.
  function automatic ucode_t ucode(upc_t upc);
    ucode_t u;
    u = '{op: OP_NOP, cond: CND_NEVER, target: STEP_IDLE, call_full: 1'b0, ret: STEP_IDLE};
    unique case (upc)
      STEP_IDLE: begin
        u = '{op: OP_IDLE, cond: CND_NOT_FIN, target: STEP_IDLE, call_full: 1'b1,
              ret: STEP_IDLE};
      end
      STEP_PUT80: begin
        u = '{op: OP_PUT_80, cond: CND_NEVER, target: STEP_IDLE, call_full: 1'b1,
              ret: STEP_PADCHK};
      end
      STEP_PADCHK: begin
        u = '{op: OP_NOP, cond: CND_POS56, target: STEP_PUTL, call_full: 1'b0,
              ret: STEP_IDLE};
      end
      STEP_PUTZ: begin
        u = '{op: OP_PUT_ZERO, cond: CND_ALWAYS, target: STEP_PADCHK, call_full: 1'b1,
              ret: STEP_PADCHK};
      end
      STEP_PUTL: begin
        u = '{op: OP_PUT_LEN, cond: CND_ALWAYS, target: STEP_PUTL, call_full: 1'b1,
              ret: STEP_EMIT};
      end
      STEP_EMIT: begin
        u = '{op: OP_EMIT, cond: CND_EMIT_MORE, target: STEP_EMIT, call_full: 1'b0,
              ret: STEP_IDLE};
      end
      STEP_LOAD: begin
        u = '{op: OP_LOAD_IV, cond: CND_ALWAYS, target: STEP_IDLE, call_full: 1'b0,
              ret: STEP_IDLE};
      end
      STEP_CMP: begin
        u = '{op: OP_CMP_START, cond: CND_NEVER, target: STEP_IDLE, call_full: 1'b0,
              ret: STEP_IDLE};
      end
      STEP_ROUND: begin
        u = '{op: OP_ROUND, cond: CND_ROUND_MORE, target: STEP_ROUND, call_full: 1'b0,
              ret: STEP_IDLE};
      end
      STEP_CMP_END: begin
        u = '{op: OP_CMP_END, cond: CND_RETURN, target: STEP_IDLE, call_full: 1'b0,
              ret: STEP_IDLE};
      end
      default: begin
        u = '{op: OP_NOP, cond: CND_ALWAYS, target: STEP_IDLE, call_full: 1'b0,
              ret: STEP_IDLE};
      end
    endcase
    return u;
  endfunction

  // Message word used by a given round.
  function automatic logic [3:0] msg_index(rnd_t i);
    logic [3:0] l;
    logic [3:0] g;
    l = i[3:0];
    g = l;
    case (i[5:4])
      2'd0: g = l;
      2'd1: g = 4'((l << 2) + l + 4'd1);
      2'd2: g = 4'((l << 1) + l + 4'd5);
      default: g = 4'((l << 3) - l);
    endcase
    return g;
  endfunction

endpackage

/* rtl/smd5_ifs.sv */
interface smd5_msg_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface smd5_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

/* rtl/smd5_ram.sv */
module smd5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/smd5_round.sv */
module smd5_round (
  input  smd5_pkg::rnd_t                   rnd,
  input  logic [smd5_pkg::WORD_W-1:0]      a,
  input  logic [smd5_pkg::WORD_W-1:0]      b,
  input  logic [smd5_pkg::WORD_W-1:0]      c,
  input  logic [smd5_pkg::WORD_W-1:0]      d,
  input  logic [smd5_pkg::WORD_W-1:0]      w,
  output logic [smd5_pkg::WORD_W-1:0]      b_new
);

  logic [smd5_pkg::WORD_W-1:0]   f;
  logic [smd5_pkg::WORD_W-1:0]   t;
  logic [2*smd5_pkg::WORD_W-1:0] dbl;
  logic [4:0]                    s;

  always_comb begin
    unique case (rnd[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = '0;
    endcase
    s     = smd5_pkg::ROUND_S[{rnd[5:4], rnd[1:0]}];
    t     = a + f + w + smd5_pkg::ROUND_K[rnd];
    dbl   = {t, t} << s;
    b_new = b + dbl[2*smd5_pkg::WORD_W-1:smd5_pkg::WORD_W];
  end

endmodule

/* rtl/seeded_md5_hash_top.sv */
// Channel   Direction  Payload                                  Notes
// msg       in         mode, data_byte                          one word per byte or finish
// digest    out        digest_word, word_index, last_word       four words per finish
// seed      in         seed_we, seed_data                       write only, no handshake
//
// A message byte is taken on each accepted transfer; each full 64-byte block then runs
// the compression routine (one start step, 64 rounds, one fold step), during which no
// byte is taken; the pace is set by the single shared round unit and the one buffer read port.
// A finish places the 0x80 byte, then a zero byte and a position check per zero byte plus
// one further position check, then each length byte, runs one compression (two when the
// 0x80 byte lands at position 56 or later), emits the four digest words and reloads the IV.
// Reset is synchronous and needs no clearing pass.
// The sequencer waits in its output step while the digest side stalls.
module seeded_md5_hash_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                seed_we,
  input  logic [31:0]         seed_data,
  smd5_msg_if.sink            msg,
  smd5_digest_if.source       digest
);

  smd5_pkg::upc_t   upc;
  smd5_pkg::upc_t   upc_next;
  smd5_pkg::upc_t   ret;
  smd5_pkg::upc_t   ret_next;
  smd5_pkg::ucode_t uc;

  logic [smd5_pkg::WORD_W-1:0] cv [4];
  logic [smd5_pkg::WORD_W-1:0] iv [4];
  logic [smd5_pkg::WORD_W-1:0] iv_next [4];
  logic [smd5_pkg::WORD_W-1:0] a;
  logic [smd5_pkg::WORD_W-1:0] b;
  logic [smd5_pkg::WORD_W-1:0] c;
  logic [smd5_pkg::WORD_W-1:0] d;
  logic [smd5_pkg::WORD_W-1:0] b_new;
  logic [smd5_pkg::WORD_W-1:0] w;
  logic [smd5_pkg::WORD_W-1:0] acc;
  logic [smd5_pkg::WORD_W-1:0] acc_next;
  logic [63:0]                 bit_count;
  logic [63:0]                 len;
  smd5_pkg::pos_t              pos;
  smd5_pkg::rnd_t              rnd;
  smd5_pkg::rnd_t              rd_rnd;
  logic [1:0]                  widx;
  logic                        out_valid;
  logic                        accept;
  logic                        put_en;
  logic [7:0]                  put_byte;
  logic                        full;
  logic                        emit_load;
  logic                        buf_we;
  logic [3:0]                  raddr;

  assign uc        = smd5_pkg::ucode(upc);
  assign msg.ready = (uc.op == smd5_pkg::OP_IDLE);
  assign accept    = msg.valid && msg.ready;
  assign full      = (pos == smd5_pkg::LAST_POS);
  assign emit_load = (uc.op == smd5_pkg::OP_EMIT) && (!out_valid || digest.ready);
  assign digest.valid = out_valid;

  always_comb begin
    put_en   = 1'b0;
    put_byte = '0;
    case (uc.op)
      smd5_pkg::OP_IDLE: begin
        put_en   = accept && !msg.mode;
        put_byte = msg.data_byte;
      end
      smd5_pkg::OP_PUT_80: begin
        put_en   = 1'b1;
        put_byte = smd5_pkg::PAD_BYTE;
      end
      smd5_pkg::OP_PUT_ZERO: begin
        put_en   = 1'b1;
        put_byte = '0;
      end
      smd5_pkg::OP_PUT_LEN: begin
        put_en   = 1'b1;
        put_byte = len[7:0];
      end
      default: begin
        put_en   = 1'b0;
        put_byte = '0;
      end
    endcase
    acc_next = {put_byte, acc[smd5_pkg::WORD_W-1:8]};
    buf_we   = put_en && (pos[1:0] == 2'd3);
    rd_rnd   = (uc.op == smd5_pkg::OP_ROUND) ? 6'(rnd + 6'd1) : '0;
    raddr    = smd5_pkg::msg_index(rd_rnd);
  end

  always_comb begin
    ret_next = ret;
    upc_next = 4'(upc + 4'd1);
    if (put_en && uc.call_full && full) begin
      upc_next = smd5_pkg::STEP_CMP;
      ret_next = uc.ret;
    end else begin
      case (uc.cond)
        smd5_pkg::CND_ALWAYS:     upc_next = uc.target;
        smd5_pkg::CND_NOT_FIN: begin
          if (!(accept && msg.mode)) begin
            upc_next = uc.target;
          end
        end
        smd5_pkg::CND_POS56: begin
          if (pos == smd5_pkg::PAD_END_POS) begin
            upc_next = uc.target;
          end
        end
        smd5_pkg::CND_EMIT_MORE: begin
          if (!(emit_load && widx == 2'd3)) begin
            upc_next = uc.target;
          end
        end
        smd5_pkg::CND_ROUND_MORE: begin
          if (rnd != '1) begin
            upc_next = uc.target;
          end
        end
        smd5_pkg::CND_RETURN:     upc_next = ret;
        default:                  upc_next = 4'(upc + 4'd1);
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      iv_next[k] = smd5_pkg::IV_WORD[k] + 32'(seed_data * smd5_pkg::SEED_MUL[k]);
    end
  end

  smd5_ram #(
    .WIDTH (smd5_pkg::WORD_W),
    .DEPTH (smd5_pkg::BUF_WORDS)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (pos[5:2]),
    .wdata (acc_next),
    .raddr (raddr),
    .rdata (w)
  );

  smd5_round u_round (
    .rnd   (rnd),
    .a     (a),
    .b     (b),
    .c     (c),
    .d     (d),
    .w     (w),
    .b_new (b_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= smd5_pkg::STEP_IDLE;
      ret       <= smd5_pkg::STEP_IDLE;
      out_valid <= 1'b0;
      widx      <= '0;
      pos       <= '0;
      bit_count <= '0;
      for (int k = 0; k < 4; k++) begin
        cv[k] <= smd5_pkg::IV_WORD[k];
        iv[k] <= smd5_pkg::IV_WORD[k];
      end
    end else begin
      upc <= upc_next;
      ret <= ret_next;

      if (put_en) begin
        acc <= acc_next;
        pos <= 6'(pos + 6'd1);
      end
      if (uc.op == smd5_pkg::OP_IDLE && put_en) begin
        bit_count <= bit_count + smd5_pkg::BYTE_BITS;
      end
      if (uc.op == smd5_pkg::OP_PUT_80) begin
        len <= bit_count;
      end
      if (uc.op == smd5_pkg::OP_PUT_LEN) begin
        len <= {8'd0, len[63:8]};
      end

      unique case (uc.op)
        smd5_pkg::OP_CMP_START: begin
          a   <= cv[0];
          b   <= cv[1];
          c   <= cv[2];
          d   <= cv[3];
          rnd <= '0;
        end
        smd5_pkg::OP_ROUND: begin
          a   <= d;
          b   <= b_new;
          c   <= b;
          d   <= c;
          rnd <= 6'(rnd + 6'd1);
        end
        smd5_pkg::OP_CMP_END: begin
          cv[0] <= cv[0] + a;
          cv[1] <= cv[1] + b;
          cv[2] <= cv[2] + c;
          cv[3] <= cv[3] + d;
        end
        smd5_pkg::OP_LOAD_IV: begin
          for (int k = 0; k < 4; k++) begin
            cv[k] <= iv[k];
          end
          bit_count <= '0;
          pos       <= '0;
        end
        default: begin
        end
      endcase

      if (emit_load) begin
        out_valid          <= 1'b1;
        digest.digest_word <= cv[widx];
        digest.word_index  <= widx;
        digest.last_word   <= (widx == 2'd3);
        widx               <= 2'(widx + 2'd1);
      end else if (digest.ready) begin
        out_valid <= 1'b0;
      end

      // A new seed reloads the chaining words and drops any partial message.
      if (seed_we) begin
        for (int k = 0; k < 4; k++) begin
          iv[k] <= iv_next[k];
          cv[k] <= iv_next[k];
        end
        bit_count <= '0;
        pos       <= '0;
      end
    end
  end

  a_word_follows: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && !digest.last_word) |=>
      (digest.valid && digest.word_index == 2'($past(digest.word_index) + 2'd1)))
    else $error("digest word did not follow in order");

  a_block_aligned: assert property (@(posedge clk) disable iff (rst)
    (uc.op == smd5_pkg::OP_ROUND) |-> (pos == '0))
    else $error("compression running on a partly filled block");

  a_seed_clears: assert property (@(posedge clk) disable iff (rst)
    seed_we |=> (bit_count == '0 && pos == '0))
    else $error("seed write did not restart the message");

endmodule
